[rtl/trpd_pkg.sv]
// Shared types and constants for the tile row pixel decoder.
`default_nettype none

package trpd_pkg;

   localparam int FRAME_WIDTH_DEF = 512;
   localparam int NUM_PENS        = 8;
   localparam int PEN_W           = 4;
   localparam int ROW_ADDR_W      = 18;
   localparam int FETCH_ADDR_W    = 28;
   localparam int PAL_W           = 7;
   localparam int POS_W           = 10;
   localparam int CODE_W          = 18;
   localparam int ATTR_W          = 6;
   localparam int ROW_W           = 5;
   localparam int WIDX_W          = 2;
   localparam int WORD_W          = 32;
   localparam int CLIP_TOP_W      = 9;
   localparam int CLIP_BOT_W      = 10;
   localparam int CSR_DATA_W      = 10;
   localparam int CSR_IDX_W       = 1;
   localparam int GEO_W           = 12;

   localparam logic [PEN_W-1:0] PEN_CLEAR = 4'hF;

   localparam logic [CLIP_TOP_W-1:0] CLIP_TOP_RST    = 9'd0;
   localparam logic [CLIP_BOT_W-1:0] CLIP_BOTTOM_RST = 10'd512;

   localparam logic signed [GEO_W-1:0] XMIN_NARROW = 12'sd64;
   localparam logic signed [GEO_W-1:0] XMIN_WIDE   = 12'sd32;
   localparam logic signed [GEO_W-1:0] X_LIMIT     = 12'sd448;

   localparam logic [PAL_W-1:0] PAL_OFF_SPRITE = 7'd0;
   localparam logic [PAL_W-1:0] PAL_OFF_BG8    = 7'd32;
   localparam logic [PAL_W-1:0] PAL_OFF_BG32   = 7'd96;

   typedef enum logic [1:0] {
      FUNC_SPRITE = 2'd0,
      FUNC_BG8    = 2'd1,
      FUNC_BG32   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_TOP    = 1'b0,
      CSR_CLIP_BOTTOM = 1'b1
   } csr_index_type;

   // per-word control from the geometry unit to the lanes and merge
   typedef struct packed {
      logic kind_ok;
      logic flip;
      logic visible;
   } tile_ctl_type;

endpackage

`default_nettype wire

[rtl/trpd_lane.sv]
// One pixel lane: picks the nibble for its screen pixel and flags opacity.
`default_nettype none

module trpd_lane
   import trpd_pkg::*;
#(
   parameter int LANE = 0
) (
   input  wire  logic [WORD_W-1:0] gfx_word,
   input  wire  logic              flip,
   output logic       [PEN_W-1:0]  pen,
   output logic                    opaque
);

   // screen pixel p < 4 sits in nibble 2p, pixel p >= 4 in nibble 2(p-4)+1
   localparam int SRC_N = LANE;
   localparam int SRC_F = NUM_PENS - 1 - LANE;
   localparam int NIB_N = (SRC_N < NUM_PENS / 2) ? 2 * SRC_N : 2 * (SRC_N - NUM_PENS / 2) + 1;
   localparam int NIB_F = (SRC_F < NUM_PENS / 2) ? 2 * SRC_F : 2 * (SRC_F - NUM_PENS / 2) + 1;

   always_comb begin
      pen    = flip ? gfx_word[PEN_W*NIB_F +: PEN_W] : gfx_word[PEN_W*NIB_N +: PEN_W];
      opaque = (pen != PEN_CLEAR);
   end

endmodule

`default_nettype wire

[rtl/trpd_geom.sv]
// Geometry unit: frame-buffer and ROM addresses, palette and clipping.
`default_nettype none

module trpd_geom
   import trpd_pkg::*;
#(
   parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
   input  wire  logic [1:0]            func,
   input  wire  logic [POS_W-1:0]      pos_x,
   input  wire  logic [POS_W-1:0]      pos_y,
   input  wire  logic [CODE_W-1:0]     tile_code,
   input  wire  logic [ATTR_W-1:0]     attr_bits,
   input  wire  logic [ROW_W-1:0]      row,
   input  wire  logic [WIDX_W-1:0]     word_index,
   input  wire  logic [CLIP_TOP_W-1:0] clip_top,
   input  wire  logic [CLIP_BOT_W-1:0] clip_bottom,
   output logic       [ROW_ADDR_W-1:0]   row_address,
   output logic       [FETCH_ADDR_W-1:0] fetch_address,
   output logic       [PAL_W-1:0]        palette_number,
   output tile_ctl_type                  ctl
);

   localparam logic [ROW_ADDR_W-1:0] FW_C = ROW_ADDR_W'(FRAME_WIDTH);

   func_type                  kind;
   logic signed [GEO_W-1:0]   x_s, y_s, dy_s, top_s, bot_s, height, xmin;
   logic [ROW_ADDR_W-1:0]     dy_u, x_u, prod;
   logic [4:0]                col;
   logic [PAL_W-1:0]          pal_off;
   logic                      word_ok, tile_vis, row_vis;

   always_comb begin
      kind    = func_type'(func);
      x_s     = {{(GEO_W-POS_W){pos_x[POS_W-1]}}, pos_x};
      y_s     = {{(GEO_W-POS_W){pos_y[POS_W-1]}}, pos_y};
      dy_s    = y_s + $signed({{(GEO_W-ROW_W){1'b0}}, row});
      top_s   = $signed({{(GEO_W-CLIP_TOP_W){1'b0}}, clip_top});
      bot_s   = $signed({{(GEO_W-CLIP_BOT_W){1'b0}}, clip_bottom});

      height        = '0;
      xmin          = XMIN_NARROW;
      pal_off       = PAL_OFF_SPRITE;
      word_ok       = 1'b0;
      col           = '0;
      fetch_address = '0;
      ctl.flip      = 1'b0;
      ctl.kind_ok   = 1'b1;
      case (kind)
         FUNC_SPRITE: begin
            height        = 12'sd16;
            ctl.flip      = attr_bits[5];
            word_ok       = ~word_index[1];
            col           = {word_index[0] ^ attr_bits[5], 3'b000};
            fetch_address = (FETCH_ADDR_W'(tile_code) << 7) + (FETCH_ADDR_W'(row) << 3)
                          + (FETCH_ADDR_W'(word_index) << 2);
         end
         FUNC_BG8: begin
            height        = 12'sd8;
            pal_off       = PAL_OFF_BG8;
            word_ok       = (word_index == 2'd1);
            fetch_address = (FETCH_ADDR_W'(tile_code) << 6) + (FETCH_ADDR_W'(row) << 3)
                          + (FETCH_ADDR_W'(word_index) << 2);
         end
         FUNC_BG32: begin
            height        = 12'sd32;
            xmin          = XMIN_WIDE;
            pal_off       = PAL_OFF_BG32;
            word_ok       = 1'b1;
            col           = {word_index, 3'b000};
            fetch_address = (FETCH_ADDR_W'(tile_code) << 9) + (FETCH_ADDR_W'(row) << 4)
                          + (FETCH_ADDR_W'(word_index) << 2);
         end
         default: begin
            ctl.kind_ok = 1'b0;
         end
      endcase

      tile_vis = !(x_s < xmin || x_s >= X_LIMIT || (y_s + height) < top_s || y_s >= bot_s);
      row_vis  = (dy_s >= top_s) && (dy_s < bot_s) &&
                 ($signed({{(GEO_W-ROW_W){1'b0}}, row}) < height);
      ctl.visible = tile_vis && row_vis && word_ok && ctl.kind_ok;

      // addresses wrap modulo 2^18, so 18-bit two's complement math is exact
      dy_u = {{(ROW_ADDR_W-GEO_W){dy_s[GEO_W-1]}}, dy_s};
      x_u  = {{(ROW_ADDR_W-GEO_W){x_s[GEO_W-1]}}, x_s};
      prod = dy_u * FW_C;
      row_address    = prod + x_u + ROW_ADDR_W'(col);
      palette_number = {2'b00, attr_bits[4:0]} + pal_off;
   end

endmodule

`default_nettype wire

[rtl/tile_row_pixel_decoder.sv]
// Top level of the tile row pixel decoder: csr, geometry, lanes, mask merge, output register.
// A response beat becomes valid in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; the single output register is the only stage,
// and a new request is taken whenever that register is empty or drains in the same cycle.
// Reset: synchronous, clears the response valid and sets clip_top 0, clip_bottom 512.
`default_nettype none

module tile_row_pixel_decoder
   import trpd_pkg::*;
#(
   parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    req_valid,
   output logic                          req_ready,
   input  wire  logic [1:0]              req_func,
   input  wire  logic [POS_W-1:0]        req_pos_x,
   input  wire  logic [POS_W-1:0]        req_pos_y,
   input  wire  logic [CODE_W-1:0]       req_tile_code,
   input  wire  logic [ATTR_W-1:0]       req_attr_bits,
   input  wire  logic [ROW_W-1:0]        req_row,
   input  wire  logic [WIDX_W-1:0]       req_word_index,
   input  wire  logic [WORD_W-1:0]       req_gfx_word,
   output logic                          rsp_valid,
   input  wire  logic                    rsp_ready,
   output logic       [ROW_ADDR_W-1:0]   rsp_row_address,
   output logic       [FETCH_ADDR_W-1:0] rsp_fetch_address,
   output logic       [PAL_W-1:0]        rsp_palette_number,
   output logic       [NUM_PENS-1:0]     rsp_write_mask,
   output logic       [PEN_W-1:0]        rsp_pen_0,
   output logic       [PEN_W-1:0]        rsp_pen_1,
   output logic       [PEN_W-1:0]        rsp_pen_2,
   output logic       [PEN_W-1:0]        rsp_pen_3,
   output logic       [PEN_W-1:0]        rsp_pen_4,
   output logic       [PEN_W-1:0]        rsp_pen_5,
   output logic       [PEN_W-1:0]        rsp_pen_6,
   output logic       [PEN_W-1:0]        rsp_pen_7,
   input  wire  logic                    csr_valid,
   output logic                          csr_ready,
   input  wire  logic [CSR_IDX_W-1:0]    csr_index,
   input  wire  logic [CSR_DATA_W-1:0]   csr_data
);

   logic [CLIP_TOP_W-1:0]   clip_top_ff;
   logic [CLIP_BOT_W-1:0]   clip_bottom_ff;
   logic [ROW_ADDR_W-1:0]   row_addr_in, row_addr_ff;
   logic [FETCH_ADDR_W-1:0] fetch_in, fetch_ff;
   logic [PAL_W-1:0]        pal_in, pal_ff;
   logic [NUM_PENS-1:0]     mask_in, mask_ff, opaque;
   logic [PEN_W-1:0]        pen_lane [NUM_PENS];
   logic [PEN_W-1:0]        pen_in   [NUM_PENS];
   logic [PEN_W-1:0]        pen_ff   [NUM_PENS];
   logic                    rsp_valid_in, rsp_valid_ff;
   logic                    accept;
   tile_ctl_type            ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_top_ff    <= CLIP_TOP_RST;
         clip_bottom_ff <= CLIP_BOTTOM_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CLIP_TOP:    clip_top_ff    <= csr_data[CLIP_TOP_W-1:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   trpd_geom #(
      .FRAME_WIDTH(FRAME_WIDTH)
   ) u_geom (
      .func          (req_func),
      .pos_x         (req_pos_x),
      .pos_y         (req_pos_y),
      .tile_code     (req_tile_code),
      .attr_bits     (req_attr_bits),
      .row           (req_row),
      .word_index    (req_word_index),
      .clip_top      (clip_top_ff),
      .clip_bottom   (clip_bottom_ff),
      .row_address   (row_addr_in),
      .fetch_address (fetch_in),
      .palette_number(pal_in),
      .ctl           (ctl)
   );

   for (genvar g = 0; g < NUM_PENS; g++) begin : g_lane
      trpd_lane #(
         .LANE(g)
      ) u_lane (
         .gfx_word(req_gfx_word),
         .flip    (ctl.flip),
         .pen     (pen_lane[g]),
         .opaque  (opaque[g])
      );
   end

   // merge: unused kind zeroes every pen; clipping only gates the mask
   always_comb begin
      mask_in = ctl.visible ? opaque : '0;
      for (int i = 0; i < NUM_PENS; i++) begin
         pen_in[i] = ctl.kind_ok ? pen_lane[i] : '0;
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_addr_ff <= ctl.kind_ok ? row_addr_in : '0;
         fetch_ff    <= fetch_in;
         pal_ff      <= ctl.kind_ok ? pal_in : '0;
         mask_ff     <= mask_in;
         pen_ff      <= pen_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_address    = row_addr_ff;
   assign rsp_fetch_address  = fetch_ff;
   assign rsp_palette_number = pal_ff;
   assign rsp_write_mask     = mask_ff;
   assign rsp_pen_0          = pen_ff[0];
   assign rsp_pen_1          = pen_ff[1];
   assign rsp_pen_2          = pen_ff[2];
   assign rsp_pen_3          = pen_ff[3];
   assign rsp_pen_4          = pen_ff[4];
   assign rsp_pen_5          = pen_ff[5];
   assign rsp_pen_6          = pen_ff[6];
   assign rsp_pen_7          = pen_ff[7];

endmodule

`default_nettype wire

[rtl/trpd_checker.sv]
// Port-level checks for the tile row pixel decoder, bound to the top level.
`default_nettype none

module trpd_checker
   import trpd_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [ROW_ADDR_W-1:0]   rsp_row_address,
   input wire logic [FETCH_ADDR_W-1:0] rsp_fetch_address,
   input wire logic [PAL_W-1:0]        rsp_palette_number,
   input wire logic [NUM_PENS-1:0]     rsp_write_mask,
   input wire logic [PEN_W-1:0]        rsp_pen_0,
   input wire logic [PEN_W-1:0]        rsp_pen_1,
   input wire logic [PEN_W-1:0]        rsp_pen_2,
   input wire logic [PEN_W-1:0]        rsp_pen_3,
   input wire logic [PEN_W-1:0]        rsp_pen_4,
   input wire logic [PEN_W-1:0]        rsp_pen_5,
   input wire logic [PEN_W-1:0]        rsp_pen_6,
   input wire logic [PEN_W-1:0]        rsp_pen_7
);

   // every accepted request beat shows up as a response the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted beat produced no response");

   // the output register never blocks input while it is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_row_address) &&
         $stable(rsp_fetch_address) && $stable(rsp_palette_number) &&
         $stable(rsp_write_mask) &&
         $stable({rsp_pen_7, rsp_pen_6, rsp_pen_5, rsp_pen_4,
                  rsp_pen_3, rsp_pen_2, rsp_pen_1, rsp_pen_0})))
      else $error("stalled response beat changed");

   // a transparent pen is never written
   a_mask_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_write_mask[0] || rsp_pen_0 != PEN_CLEAR) &&
                     (!rsp_write_mask[1] || rsp_pen_1 != PEN_CLEAR) &&
                     (!rsp_write_mask[2] || rsp_pen_2 != PEN_CLEAR) &&
                     (!rsp_write_mask[3] || rsp_pen_3 != PEN_CLEAR) &&
                     (!rsp_write_mask[4] || rsp_pen_4 != PEN_CLEAR) &&
                     (!rsp_write_mask[5] || rsp_pen_5 != PEN_CLEAR) &&
                     (!rsp_write_mask[6] || rsp_pen_6 != PEN_CLEAR) &&
                     (!rsp_write_mask[7] || rsp_pen_7 != PEN_CLEAR)))
      else $error("write mask set on transparent pen");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tile_row_pixel_decoder trpd_checker u_trpd_checker (.*);

`default_nettype wire
